// ===== rtl/pngtxt_pkg.sv =====
// Constants, types and helpers for the PNG text-chunk metadata parser.
package pngtxt_pkg;

	// Result kinds.
	localparam logic [1:0] KIND_SEED = 2'd0;
	localparam logic [1:0] KIND_HOST = 2'd1;
	localparam logic [1:0] KIND_PACK = 2'd2;
	localparam logic [1:0] KIND_BAD  = 2'd3;

	localparam int HEX_CHARS_DEFAULT = 8;

	localparam logic [31:0] TEXT_TYPE = 32'h7445_5874;

	localparam logic [7:0] SIG_BYTES [8] = '{
		8'd137, 8'd80, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10
	};

	localparam int KW_COUNT = 3;

	// Keyword bytes, zero padded: seed, host options, texture pack.
	localparam logic [7:0] KW_CHARS [KW_COUNT][16] = '{
		'{8'h34, 8'h4A, 8'h5F, 8'h53, 8'h45, 8'h45, 8'h44, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h34, 8'h4A, 8'h5F, 8'h48, 8'h4F, 8'h53, 8'h54, 8'h4F,
		  8'h50, 8'h54, 8'h49, 8'h4F, 8'h4E, 8'h53, 8'h00, 8'h00},
		'{8'h34, 8'h4A, 8'h5F, 8'h54, 8'h45, 8'h58, 8'h54, 8'h55,
		  8'h52, 8'h45, 8'h50, 8'h41, 8'h43, 8'h4B, 8'h00, 8'h00}
	};

	localparam logic [4:0] KW_LEN [KW_COUNT] = '{5'd7, 5'd14, 5'd14};

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_dig_t;

	function automatic hex_dig_t hex_digit(input logic [7:0] c);
		hex_dig_t d;
		d.ok  = 1'b1;
		d.val = 4'd0;
		case (c) inside
			[8'h30:8'h39]: d.val = 4'(c - 8'h30);
			[8'h61:8'h66]: d.val = 4'(c - 8'h57);
			[8'h41:8'h46]: d.val = 4'(c - 8'h37);
			default:       d.ok  = 1'b0;
		endcase
		return d;
	endfunction

endpackage

// ===== rtl/png_text_chunk_metadata_parser_unit.sv =====
// PNG text-chunk metadata parser: signature check, chunk walk and keyword values.
//
//  channel   signals                               dir
//  data      data_valid data_ready data_byte last_byte   in
//  result    result_valid result_ready result_kind value out
//
// One byte per cycle sustained while no result stalls. A byte is held in the input
// register and its result, if any, is registered into the result register; the parser
// state advances once per byte in that single step. Reset clears all parser
// state to the signature check. A stalled result holds the input register, and
// the input register keeps taking bytes whenever it can pass its byte on.
module png_text_chunk_metadata_parser_unit #(
	parameter int HEX_VALUE_CHARS = pngtxt_pkg::HEX_CHARS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  result_kind,
	output logic [31:0] value
);
	import pngtxt_pkg::*;

	typedef enum logic [2:0] {
		PH_SIG  = 3'd0,
		PH_LEN  = 3'd1,
		PH_TYPE = 3'd2,
		PH_DATA = 3'd3,
		PH_CRC  = 3'd4,
		PH_HALT = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		VM_KEY  = 2'd0,
		VM_SEED = 2'd1,
		VM_HOST = 2'd2,
		VM_PACK = 2'd3
	} vmode_t;

	// Input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// Parser state
	phase_t      phase_q;
	logic [31:0] fc_q;
	logic [31:0] len_q;
	logic [31:0] kind_q;
	logic [4:0]  pos_q;
	logic [2:0]  flags_q;
	vmode_t      mode_q;
	logic [3:0]  cnt_q;
	logic [31:0] acc_q;
	logic        open_q;

	// Result register
	logic        result_valid_q;
	logic [1:0]  result_kind_q;
	logic [31:0] value_q;

	phase_t      nx_phase;
	logic [31:0] nx_fc;
	logic [31:0] nx_len;
	logic [31:0] nx_kind;
	logic [4:0]  nx_pos;
	logic [2:0]  nx_flags;
	vmode_t      nx_mode;
	logic [3:0]  nx_cnt;
	logic [31:0] nx_acc;
	logic        nx_open;
	logic        res_v;
	logic [1:0]  res_kind;
	logic [31:0] res_val;
	logic        adv;

	assign adv        = valid_s1 && (!result_valid_q || result_ready);
	assign data_ready = !valid_s1 || adv;

	always_comb begin
		logic     chunk_end;
		logic     hit_seed;
		logic     hit_host;
		logic     hit_pack;
		hex_dig_t dig;
		nx_phase = phase_q;
		nx_fc    = fc_q;
		nx_len   = len_q;
		nx_kind  = kind_q;
		nx_pos   = pos_q;
		nx_flags = flags_q;
		nx_mode  = mode_q;
		nx_cnt   = cnt_q;
		nx_acc   = acc_q;
		nx_open  = open_q;
		res_v    = 1'b0;
		res_kind = KIND_SEED;
		res_val  = '0;
		chunk_end = (fc_q + 32'd1) == len_q;
		hit_seed = flags_q[0] && (pos_q == KW_LEN[0]);
		hit_host = flags_q[1] && (pos_q == KW_LEN[1]);
		hit_pack = flags_q[2] && (pos_q == KW_LEN[2]);
		dig = hex_digit(byte_s1);
		case (phase_q)
			PH_SIG: begin
				if (byte_s1 != SIG_BYTES[fc_q[2:0]]) begin
					res_v    = 1'b1;
					res_kind = KIND_BAD;
					nx_phase = PH_HALT;
				end else if (fc_q[2:0] == 3'd7) begin
					nx_phase = PH_LEN;
					nx_fc    = '0;
				end else begin
					nx_fc = fc_q + 32'd1;
				end
			end
			PH_LEN: begin
				nx_len = {len_q[23:0], byte_s1};
				if (fc_q[1:0] == 2'd3) begin
					nx_phase = PH_TYPE;
					nx_fc    = '0;
				end else begin
					nx_fc = fc_q + 32'd1;
				end
			end
			PH_TYPE: begin
				nx_kind = {kind_q[23:0], byte_s1};
				if (fc_q[1:0] == 2'd3) begin
					nx_fc    = '0;
					nx_phase = (len_q == '0) ? PH_CRC : PH_DATA;
					nx_pos   = '0;
					nx_flags = '1;
					nx_mode  = VM_KEY;
					nx_cnt   = '0;
					nx_acc   = '0;
					nx_open  = 1'b1;
				end else begin
					nx_fc = fc_q + 32'd1;
				end
			end
			PH_DATA: begin
				if (kind_q == TEXT_TYPE) begin
					case (mode_q)
						VM_KEY: begin
							if (byte_s1 == 8'd0) begin
								nx_pos   = '0;
								nx_flags = '1;
								if (hit_host || hit_pack) begin
									nx_mode = hit_pack ? VM_PACK : VM_HOST;
									nx_cnt  = '0;
									nx_acc  = '0;
									nx_open = 1'b1;
									// An empty value at the chunk end still yields a zero word.
									if (chunk_end) begin
										res_v    = 1'b1;
										res_kind = hit_pack ? KIND_PACK : KIND_HOST;
									end
								end else if (hit_seed) begin
									nx_mode = VM_SEED;
								end
							end else begin
								for (int k = 0; k < KW_COUNT; k++) begin
									if (pos_q >= KW_LEN[k] || byte_s1 != KW_CHARS[k][pos_q[3:0]])
										nx_flags[k] = 1'b0;
								end
								if (pos_q != 5'd31)
									nx_pos = pos_q + 5'd1;
							end
						end
						VM_SEED: begin
							if (byte_s1 == 8'd0) begin
								nx_mode = VM_KEY;
							end else begin
								res_v    = 1'b1;
								res_kind = KIND_SEED;
								res_val  = {24'd0, byte_s1};
							end
						end
						default: begin
							res_kind = (mode_q == VM_HOST) ? KIND_HOST : KIND_PACK;
							res_val  = acc_q;
							if (byte_s1 == 8'd0) begin
								res_v   = 1'b1;
								nx_mode = VM_KEY;
							end else begin
								if (open_q) begin
									if (dig.ok)
										nx_acc = {acc_q[27:0], dig.val};
									else
										nx_open = 1'b0;
								end
								nx_cnt  = cnt_q + 4'd1;
								res_val = nx_acc;
								if (nx_cnt >= 4'(HEX_VALUE_CHARS) || chunk_end) begin
									res_v   = 1'b1;
									nx_mode = VM_KEY;
								end
							end
						end
					endcase
					if (chunk_end) begin
						nx_pos   = '0;
						nx_flags = '1;
						nx_mode  = VM_KEY;
						nx_cnt   = '0;
						nx_acc   = '0;
						nx_open  = 1'b1;
					end
				end
				if (chunk_end) begin
					nx_phase = PH_CRC;
					nx_fc    = '0;
				end else begin
					nx_fc = fc_q + 32'd1;
				end
			end
			PH_CRC: begin
				if (fc_q[1:0] == 2'd3) begin
					nx_phase = PH_LEN;
					nx_fc    = '0;
				end else begin
					nx_fc = fc_q + 32'd1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
			result_kind_q  <= KIND_SEED;
			value_q        <= '0;
			phase_q        <= PH_SIG;
			fc_q           <= '0;
			len_q          <= '0;
			kind_q         <= '0;
			pos_q          <= '0;
			flags_q        <= '1;
			mode_q         <= VM_KEY;
			cnt_q          <= '0;
			acc_q          <= '0;
			open_q         <= 1'b1;
		end else begin
			if (data_ready)
				valid_s1 <= data_valid;
			if (adv)
				result_valid_q <= res_v;
			else if (result_ready)
				result_valid_q <= 1'b0;
			if (adv && res_v) begin
				result_kind_q <= res_kind;
				value_q       <= res_val;
			end
			if (adv) begin
				// The final byte of a file puts the parser back to its reset state.
				if (last_s1) begin
					phase_q <= PH_SIG;
					fc_q    <= '0;
					len_q   <= '0;
					kind_q  <= '0;
					pos_q   <= '0;
					flags_q <= '1;
					mode_q  <= VM_KEY;
					cnt_q   <= '0;
					acc_q   <= '0;
					open_q  <= 1'b1;
				end else begin
					phase_q <= nx_phase;
					fc_q    <= nx_fc;
					len_q   <= nx_len;
					kind_q  <= nx_kind;
					pos_q   <= nx_pos;
					flags_q <= nx_flags;
					mode_q  <= nx_mode;
					cnt_q   <= nx_cnt;
					acc_q   <= nx_acc;
					open_q  <= nx_open;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (data_valid && data_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	assign result_valid = result_valid_q;
	assign result_kind  = result_kind_q;
	assign value        = value_q;

	a_halt_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && phase_q == PH_HALT && !last_s1) |=> phase_q == PH_HALT)
		else $error("halted parser left the halt phase without a final byte");

	a_bad_from_sig: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res_v && res_kind == KIND_BAD) |-> phase_q == PH_SIG)
		else $error("bad signature reported outside the signature check");

	a_hex_count: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == VM_HOST || mode_q == VM_PACK) |-> cnt_q < 4'(HEX_VALUE_CHARS))
		else $error("hex character count passed its limit");

	a_sig_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SIG |-> fc_q < 32'd8)
		else $error("signature byte count out of range");

endmodule
